/* rtl/brrip_replacement_policy_core_defines.svh */
// Assertion macros used by the BRRIP replacement policy top level.
`ifndef BRRIP_REPLACEMENT_POLICY_CORE_DEFINES_SVH
`define BRRIP_REPLACEMENT_POLICY_CORE_DEFINES_SVH

// The antecedent implies the consequent in the same cycle.
`define BRRIP_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The antecedent implies the consequent in the following cycle.
`define BRRIP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/brrip_pkg.sv */
// Package with the constants, codes and types of the BRRIP replacement policy block.
package brrip_pkg;

    localparam int WAYS      = 16;
    localparam int SETS      = 64;
    localparam int RRPV_BITS = 2;

    localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int SET_W = (SETS > 1) ? $clog2(SETS) : 1;

    localparam int CMD_W     = 2;
    localparam int SET_IDX_W = 6;
    localparam int WAY_IDX_W = 4;
    localparam int DRAW_W    = 7;
    localparam int PCT_W     = 7;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 7;

    localparam logic [RRPV_BITS-1:0] RRPV_MAX  = {RRPV_BITS{1'b1}};
    localparam logic [RRPV_BITS-1:0] RRPV_LONG = RRPV_BITS'(RRPV_MAX - 1'b1);
    localparam logic [PCT_W-1:0]     PCT_RESET = PCT_W'(3);

    localparam logic [CMD_W-1:0] CMD_HIT    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_FILL   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_INVAL  = 2'd2;
    localparam logic [CMD_W-1:0] CMD_VICTIM = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_HIT_MODE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_PCT = 1'b1;

    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    typedef enum logic [2:0] {
        OP_NONE,
        OP_HIT_CLEAR,
        OP_HIT_DEC,
        OP_FILL,
        OP_INVAL,
        OP_VICTIM
    } op_t;

    typedef struct packed {
        op_t                  op;
        logic [SET_W-1:0]     set_addr;
        logic [WAY_W-1:0]     way;
        logic [RRPV_BITS-1:0] fill_val;
    } entry_t;

    typedef struct packed {
        logic empty;
        logic full;
    } q_status_t;

    typedef struct packed {
        logic busy;
        logic fire;
    } back_status_t;

    typedef logic [WAYS-1:0][RRPV_BITS-1:0] rrpv_row_t;
    typedef logic [WAYS-1:0]                valid_row_t;

endpackage

/* rtl/brrip_front.sv */
// Front end: configuration registers, input word acceptance and command classification.
module brrip_front
    import brrip_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DAT_W-1:0] cfg_data,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [CMD_W-1:0]     command,
    input  logic [SET_IDX_W-1:0] set_index,
    input  logic [WAY_IDX_W-1:0] way_index,
    input  logic [DRAW_W-1:0]    rand_draw,
    input  q_status_t            q_status,
    output logic                 q_push,
    output entry_t               q_data
);

    logic             hit_mode_reg;
    logic             hit_mode_next;
    logic [PCT_W-1:0] long_pct_reg;
    logic [PCT_W-1:0] long_pct_next;
    logic             set_ok;
    logic             way_ok;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        hit_mode_next = hit_mode_reg;
        long_pct_next = long_pct_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_HIT_MODE: hit_mode_next = cfg_data[0];
                CFG_LONG_PCT: long_pct_next = PCT_W'(cfg_data);
                default:      hit_mode_next = hit_mode_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_mode_reg <= 1'b0;
            long_pct_reg <= PCT_RESET;
        end
        else
        begin
            hit_mode_reg <= hit_mode_next;
            long_pct_reg <= long_pct_next;
        end
    end

    assign in_stall = q_status.full;
    assign q_push   = in_valid && !in_stall;

    assign set_ok = 32'(set_index) < 32'(SETS);
    assign way_ok = 32'(way_index) < 32'(WAYS);

    always_comb
    begin
        q_data.set_addr = SET_W'(set_index);
        q_data.way      = WAY_W'(way_index);
        q_data.fill_val = (rand_draw <= long_pct_reg) ? RRPV_LONG : RRPV_MAX;
        q_data.op       = OP_NONE;
        unique case (command)
            CMD_HIT:    q_data.op = way_ok ? (hit_mode_reg ? OP_HIT_CLEAR : OP_HIT_DEC) : OP_NONE;
            CMD_FILL:   q_data.op = way_ok ? OP_FILL : OP_NONE;
            CMD_INVAL:  q_data.op = way_ok ? OP_INVAL : OP_NONE;
            CMD_VICTIM: q_data.op = OP_VICTIM;
            default:    q_data.op = OP_NONE;
        endcase
        if (!set_ok)
        begin
            q_data.op = OP_NONE;
        end
    end

endmodule

/* rtl/brrip_queue.sv */
// Short queue of classified words between the front end and the back end.
module brrip_queue
    import brrip_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  entry_t    push_data,
    input  logic      pop,
    output entry_t    head,
    output q_status_t status
);

    entry_t              entries [QDEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg;
    logic [QCNT_W-1:0]   count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (32'(wr_ptr_reg) == QDEPTH - 1) ? '0 : QPTR_W'(wr_ptr_reg + 1'b1);
        end
        if (pop)
        begin
            rd_ptr_next = (32'(rd_ptr_reg) == QDEPTH - 1) ? '0 : QPTR_W'(rd_ptr_reg + 1'b1);
        end
        if (push && !pop)
        begin
            count_next = QCNT_W'(count_reg + 1'b1);
        end
        else if (pop && !push)
        begin
            count_next = QCNT_W'(count_reg - 1'b1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries[wr_ptr_reg] <= push_data;
        end
    end

    assign head         = entries[rd_ptr_reg];
    assign status.empty = (count_reg == '0);
    assign status.full  = (32'(count_reg) == QDEPTH);

endmodule

/* rtl/brrip_back.sv */
// Back end: set row memory, read-modify-write of one set per word and the result register.
module brrip_back
    import brrip_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  entry_t               q_head,
    input  q_status_t            q_status,
    output logic                 q_pop,
    output back_status_t         status,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [WAY_IDX_W-1:0] victim_way,
    output logic                 victim_was_free
);

    typedef enum logic [1:0] {
        S_READ = 2'b01,
        S_EXEC = 2'b10
    } state_t;

    state_t     state_reg;
    state_t     state_next;
    rrpv_row_t  rrpv_mem  [SETS];
    valid_row_t valid_mem [SETS];
    logic [SETS-1:0] row_init_reg;
    logic [SETS-1:0] row_init_next;

    entry_t     cur_reg;
    rrpv_row_t  rd_rrpv_reg;
    valid_row_t rd_valid_reg;
    logic       rd_init_reg;

    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic [WAY_IDX_W-1:0] victim_way_reg;
    logic                 victim_was_free_reg;

    logic       start;
    logic       fire;
    logic       do_write;
    rrpv_row_t  row_rrpv;
    valid_row_t row_valid;
    rrpv_row_t  new_rrpv;
    valid_row_t new_valid;
    logic       free_any;
    logic [WAY_W-1:0] free_way;
    logic [WAYS-1:0]  is_max;
    logic [WAY_W-1:0] max_way;
    logic [RRPV_BITS-1:0] best;
    logic [RRPV_BITS-1:0] diff;
    logic [WAY_IDX_W-1:0] res_way;
    logic                 res_free;

    assign start = (state_reg == S_READ) && !q_status.empty;
    assign fire  = (state_reg == S_EXEC) && (!out_valid_reg || !out_stall);
    assign q_pop = start;

    assign status.busy = (state_reg == S_EXEC);
    assign status.fire = fire;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_READ:  state_next = start ? S_EXEC : S_READ;
            S_EXEC:  state_next = fire ? S_READ : S_EXEC;
            default: state_next = S_READ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            cur_reg      <= q_head;
            rd_rrpv_reg  <= rrpv_mem[q_head.set_addr];
            rd_valid_reg <= valid_mem[q_head.set_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && do_write)
        begin
            rrpv_mem[cur_reg.set_addr]  <= new_rrpv;
            valid_mem[cur_reg.set_addr] <= new_valid;
        end
    end

    assign row_rrpv  = rd_init_reg ? rd_rrpv_reg : '0;
    assign row_valid = rd_init_reg ? rd_valid_reg : '0;

    always_comb
    begin
        free_any = 1'b0;
        free_way = '0;
        for (int w = WAYS - 1; w >= 0; w--)
        begin
            if (!row_valid[w])
            begin
                free_any = 1'b1;
                free_way = WAY_W'(w);
            end
        end
    end

    always_comb
    begin
        for (int w = 0; w < WAYS; w++)
        begin
            is_max[w] = 1'b1;
            for (int v = 0; v < WAYS; v++)
            begin
                if (row_rrpv[v] > row_rrpv[w])
                begin
                    is_max[w] = 1'b0;
                end
            end
        end
        max_way = '0;
        for (int w = WAYS - 1; w >= 0; w--)
        begin
            if (is_max[w])
            begin
                max_way = WAY_W'(w);
            end
        end
    end

    assign best = row_rrpv[max_way];
    assign diff = RRPV_BITS'(RRPV_MAX - best);

    always_comb
    begin
        logic [RRPV_BITS:0] sum;
        sum       = '0;
        new_rrpv  = row_rrpv;
        new_valid = row_valid;
        do_write  = 1'b1;
        res_way   = '0;
        res_free  = 1'b0;
        case (cur_reg.op)
            OP_HIT_CLEAR:
            begin
                new_rrpv[cur_reg.way] = '0;
            end
            OP_HIT_DEC:
            begin
                if (row_rrpv[cur_reg.way] != '0)
                begin
                    new_rrpv[cur_reg.way] = RRPV_BITS'(row_rrpv[cur_reg.way] - 1'b1);
                end
            end
            OP_FILL:
            begin
                new_rrpv[cur_reg.way]  = cur_reg.fill_val;
                new_valid[cur_reg.way] = 1'b1;
            end
            OP_INVAL:
            begin
                new_valid[cur_reg.way] = 1'b0;
            end
            OP_VICTIM:
            begin
                if (free_any)
                begin
                    do_write = 1'b0;
                    res_way  = WAY_IDX_W'(free_way);
                    res_free = 1'b1;
                end
                else
                begin
                    res_way = WAY_IDX_W'(max_way);
                    for (int w = 0; w < WAYS; w++)
                    begin
                        sum = {1'b0, row_rrpv[w]} + {1'b0, diff};
                        new_rrpv[w] = (sum > {1'b0, RRPV_MAX}) ? RRPV_MAX : sum[RRPV_BITS-1:0];
                    end
                end
            end
            default:
            begin
                do_write = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        row_init_next = row_init_reg;
        if (fire && do_write)
        begin
            row_init_next[cur_reg.set_addr] = 1'b1;
        end
        out_valid_next = out_valid_reg && out_stall;
        if (fire)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_READ;
            row_init_reg  <= '0;
            rd_init_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            row_init_reg  <= row_init_next;
            out_valid_reg <= out_valid_next;
            if (start)
            begin
                rd_init_reg <= row_init_reg[q_head.set_addr];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            victim_way_reg      <= res_way;
            victim_was_free_reg <= res_free;
        end
    end

    assign out_valid       = out_valid_reg;
    assign victim_way      = victim_way_reg;
    assign victim_was_free = victim_was_free_reg;

endmodule

/* rtl/brrip_replacement_policy_core.sv */
// Top level of the BRRIP replacement policy block.
// Each word passes through the back-end states S_READ, which reads the addressed set
// row from the row memory, and S_EXEC, which updates it, writes it back and loads the
// result register; the back end takes no new word until the last one has left S_EXEC.
// A front end classifies words into a two-entry queue, so up to two words are accepted
// while the back end or the result side is stalled. On its way to the output a word
// passes through the queue, the row read registers and the result register.
// No clearing pass is needed after reset: a per-set flag marks rows that were never
// written, and those read as all ways invalid with zero RRPV.
`include "brrip_replacement_policy_core_defines.svh"

module brrip_replacement_policy_core
    import brrip_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DAT_W-1:0] cfg_data,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [CMD_W-1:0]     command,
    input  logic [SET_IDX_W-1:0] set_index,
    input  logic [WAY_IDX_W-1:0] way_index,
    input  logic [DRAW_W-1:0]    rand_draw,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [WAY_IDX_W-1:0] victim_way,
    output logic                 victim_was_free
);

    q_status_t    q_status;
    logic         q_push;
    logic         q_pop;
    entry_t       q_data;
    entry_t       q_head;
    back_status_t back_status;

    brrip_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .command   (command),
        .set_index (set_index),
        .way_index (way_index),
        .rand_draw (rand_draw),
        .q_status  (q_status),
        .q_push    (q_push),
        .q_data    (q_data)
    );

    brrip_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_data),
        .pop       (q_pop),
        .head      (q_head),
        .status    (q_status)
    );

    brrip_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .q_head          (q_head),
        .q_status        (q_status),
        .q_pop           (q_pop),
        .status          (back_status),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .victim_way      (victim_way),
        .victim_was_free (victim_was_free)
    );

    `BRRIP_ASSERT_IMP(a_pop_not_empty, q_pop, !q_status.empty, "pop from an empty queue")
    `BRRIP_ASSERT_IMP(a_pop_when_idle, q_pop, !back_status.busy, "pop while a word is in flight")
    `BRRIP_ASSERT_NEXT(a_fire_result, back_status.fire, out_valid, "executed word gave no result")
    `BRRIP_ASSERT_IMP(a_queue_flags, 1'b1, !(q_status.empty && q_status.full), "queue flags clash")

endmodule
